[rtl/rtd_pkg.sv]
// shared types, constants and helpers of the rtd code to temperature converter
package rtd_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 512;
   localparam int CODE_WIDTH  = 24;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // stream payload widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 16;
   localparam int TEMP_W     = 11;

   // csr register indexes
   localparam logic [2:0] CSR_LOW_LIMIT  = 3'd0;
   localparam logic [2:0] CSR_HIGH_LIMIT = 3'd1;
   localparam logic [2:0] CSR_LOW_TEMP   = 3'd2;
   localparam logic [2:0] CSR_HIGH_TEMP  = 3'd3;
   localparam logic [2:0] CSR_OFFSET     = 3'd4;
   localparam logic [2:0] CSR_ENTRIES    = 3'd5;

   // csr reset values
   localparam logic [23:0]        RST_LOW_LIMIT  = 24'd2893443;
   localparam logic [23:0]        RST_HIGH_LIMIT = 24'd8106557;
   localparam logic signed [10:0] RST_LOW_TEMP   = -11'sd30;
   localparam logic signed [10:0] RST_HIGH_TEMP  = 11'sd400;
   localparam logic [8:0]         RST_OFFSET     = 9'd30;
   localparam logic [9:0]         RST_ENTRIES    = 10'd431;

   // operation codes on req_tuser
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   // range status codes
   localparam logic [1:0] RANGE_OK   = 2'd0;
   localparam logic [1:0] RANGE_LOW  = 2'd1;
   localparam logic [1:0] RANGE_HIGH = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_CLAMP,
      CMD_SEARCH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic [IDX_W-1:0]            index;
      logic [CODE_WIDTH-1:0]       code;
      logic signed [TEMP_W-1:0]    temp;
      logic [1:0]                  status;
   } cmd_type;

   typedef struct packed {
      logic [23:0]                 low_limit;
      logic [23:0]                 high_limit;
      logic signed [TEMP_W-1:0]    low_temp;
      logic signed [TEMP_W-1:0]    high_temp;
      logic [8:0]                  offset;
      logic [IDX_W-1:0]            last_index;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PROBE,
      BK_NB_LO,
      BK_NB_MID,
      BK_NB_HI,
      BK_DONE
   } back_state_type;

   function automatic logic [CODE_WIDTH-1:0] code_dist(
      input logic [CODE_WIDTH-1:0] a,
      input logic [CODE_WIDTH-1:0] b
   );
      logic [CODE_WIDTH-1:0] d;
      if (a >= b) begin
         d = a - b;
      end else begin
         d = b - a;
      end
      return d;
   endfunction

endpackage

[rtl/rtd_ram.sv]
// generic single write port ram with registered read
module rtd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/rtd_front.sv]
// front end: accepts request transfers and classifies them into queue commands
module rtd_front (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rtd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                        req_tuser,
   input  rtd_pkg::cfg_type            cfg,
   input  logic                        q_full,
   output logic                        q_push,
   output rtd_pkg::cmd_type            q_cmd
);
   import rtd_pkg::*;

   logic [8:0]            entry_index;
   logic [23:0]           entry_code;
   logic [23:0]           sample_code;
   logic [CODE_WIDTH-1:0] sample_w;
   logic                  below;
   logic                  above;
   logic                  index_ok;

   assign entry_index = req_tdata[8:0];
   assign entry_code  = req_tdata[32:9];
   assign sample_code = req_tdata[56:33];

   assign sample_w = CODE_WIDTH'(32'(sample_code));
   assign below    = 32'(sample_w) < 32'(cfg.low_limit);
   assign above    = 32'(sample_w) > 32'(cfg.high_limit);
   // loads past the table end are taken and dropped
   assign index_ok = 32'(entry_index) < 32'(TABLE_DEPTH);

   assign req_tready = !q_full;

   always_comb begin
      q_cmd.kind   = CMD_SEARCH;
      q_cmd.index  = IDX_W'(32'(entry_index));
      q_cmd.code   = sample_w;
      q_cmd.temp   = cfg.low_temp;
      q_cmd.status = RANGE_OK;
      q_push       = req_tvalid && !q_full;
      if (req_tuser == OP_LOAD) begin
         q_cmd.kind = CMD_LOAD;
         q_cmd.code = CODE_WIDTH'(32'(entry_code));
         q_push     = req_tvalid && !q_full && index_ok;
      end else if (below) begin
         // low clamp wins when both limits are crossed
         q_cmd.kind   = CMD_CLAMP;
         q_cmd.temp   = cfg.low_temp;
         q_cmd.status = RANGE_LOW;
      end else if (above) begin
         q_cmd.kind   = CMD_CLAMP;
         q_cmd.temp   = cfg.high_temp;
         q_cmd.status = RANGE_HIGH;
      end
   end

endmodule

[rtl/rtd_cmd_queue.sv]
// short command queue between front and back
module rtd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rtd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output rtd_pkg::cmd_type head_cmd
);
   import rtd_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/rtd_back.sv]
// back end: table writes, binary search with neighbor pick, result register
module rtd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rtd_pkg::cfg_type              cfg,
   input  logic                          head_valid,
   input  rtd_pkg::cmd_type              head_cmd,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [rtd_pkg::TEMP_W-1:0] rsp_temp,
   output logic [1:0]                    rsp_status
);
   import rtd_pkg::*;

   back_state_type           state_ff, state_in;
   logic [IDX_W-1:0]         first_ff, first_in;
   logic [IDX_W-1:0]         last_ff, last_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CODE_WIDTH-1:0]    sample_ff, sample_in;
   logic [CODE_WIDTH-1:0]    dlo_ff, dlo_in;
   logic [CODE_WIDTH-1:0]    dmid_ff, dmid_in;
   logic                     lo_wins_ff, lo_wins_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [TEMP_W-1:0] out_temp_ff, out_temp_in;
   logic [1:0]               out_status_ff, out_status_in;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [CODE_WIDTH-1:0]    ram_wdata;
   logic [IDX_W-1:0]         ram_raddr;
   logic [CODE_WIDTH-1:0]    ram_rdata;

   logic                     out_free;
   logic [IDX_W-1:0]         lo_idx;
   logic [IDX_W-1:0]         hi_idx;
   logic [IDX_W-1:0]         f_nx;
   logic [IDX_W-1:0]         l_nx;
   logic [IDX_W-1:0]         lo_nx;
   logic [CODE_WIDTH-1:0]    d_cur;

   rtd_ram #(
      .WIDTH(CODE_WIDTH),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign out_free = !out_valid_ff || rsp_tready;
   assign lo_idx   = (first_ff == '0) ? '0 : first_ff - IDX_W'(1);
   assign hi_idx   = (first_ff < cfg.last_index) ? first_ff + IDX_W'(1) : first_ff;
   assign d_cur    = code_dist(ram_rdata, sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff      <= first_in;
      last_ff       <= last_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      sample_ff     <= sample_in;
      dlo_ff        <= dlo_in;
      dmid_ff       <= dmid_in;
      lo_wins_ff    <= lo_wins_in;
      out_temp_ff   <= out_temp_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      sample_in     = sample_ff;
      dlo_in        = dlo_ff;
      dmid_in       = dmid_ff;
      lo_wins_in    = lo_wins_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_temp_in   = out_temp_ff;
      out_status_in = out_status_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = head_cmd.index;
      ram_wdata     = head_cmd.code;
      ram_raddr     = first_ff;
      f_nx          = first_ff;
      l_nx          = last_ff;
      lo_nx         = lo_idx;

      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               case (head_cmd.kind)
                  CMD_LOAD: begin
                     pop    = 1'b1;
                     ram_we = 1'b1;
                  end
                  CMD_CLAMP: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        out_valid_in  = 1'b1;
                        out_temp_in   = head_cmd.temp;
                        out_status_in = head_cmd.status;
                     end
                  end
                  CMD_SEARCH: begin
                     pop       = 1'b1;
                     sample_in = head_cmd.code;
                     first_in  = '0;
                     last_in   = cfg.last_index;
                     if (cfg.last_index != '0) begin
                        mid_in    = cfg.last_index >> 1;
                        ram_raddr = cfg.last_index >> 1;
                        state_in  = BK_PROBE;
                     end else begin
                        // one entry only: straight to the neighbor reads
                        ram_raddr = '0;
                        state_in  = BK_NB_LO;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         BK_PROBE: begin
            if (ram_rdata == sample_ff) begin
               idx_in   = mid_ff;
               state_in = BK_DONE;
            end else begin
               if (ram_rdata < sample_ff) begin
                  f_nx  = mid_ff + IDX_W'(1);
                  l_nx  = last_ff;
                  lo_nx = mid_ff;
               end else begin
                  f_nx  = first_ff;
                  l_nx  = (mid_ff == '0) ? '0 : mid_ff - IDX_W'(1);
                  lo_nx = lo_idx;
               end
               first_in = f_nx;
               last_in  = l_nx;
               if (f_nx < l_nx) begin
                  mid_in    = IDX_W'(((IDX_W+1)'(f_nx) + (IDX_W+1)'(l_nx)) >> 1);
                  ram_raddr = IDX_W'(((IDX_W+1)'(f_nx) + (IDX_W+1)'(l_nx)) >> 1);
               end else begin
                  // search closed: start with the lower neighbor
                  ram_raddr = lo_nx;
                  state_in  = BK_NB_LO;
               end
            end
         end
         BK_NB_LO: begin
            dlo_in    = d_cur;
            ram_raddr = first_ff;
            state_in  = BK_NB_MID;
         end
         BK_NB_MID: begin
            dmid_in    = d_cur;
            lo_wins_in = dlo_ff < d_cur;
            ram_raddr  = hi_idx;
            state_in   = BK_NB_HI;
         end
         BK_NB_HI: begin
            if (lo_wins_ff) begin
               idx_in = lo_idx;
            end else if (dmid_ff < d_cur) begin
               idx_in = first_ff;
            end else begin
               idx_in = hi_idx;
            end
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_temp_in   = TEMP_W'(32'(idx_ff) - 32'(cfg.offset));
               out_status_in = RANGE_OK;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_temp   = out_temp_ff;
   assign rsp_status = out_status_ff;

endmodule

[rtl/rtd_code_to_temperature_top.sv]
// top level of the rtd code to temperature converter
//
//  channel | direction | transfer on             | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  req     | in        | req_tvalid & req_tready | tuser operation, tdata entry/sample data
//  rsp     | out       | rsp_tvalid & rsp_tready | tdata temperature, range_status
//  csr     | in        | csr_we                  | csr_index register, csr_wdata value
//
// load transfers write the table from the queue head, and clamped conversions go straight
// to the output register; in-range conversions take an issue step, the binary search probes,
// three neighbor reads and a result step; an exact hit skips the neighbor reads; one table
// read port, one probe per cycle
// reset is synchronous and clears control state only; the code table is not cleared
// a two-entry queue lets the front keep taking transfers while the back searches or
// while a finished result waits in the output register for rsp_tready
module rtd_code_to_temperature_top (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [8:0] entry_index, [32:9] entry_code, [56:33] sample_code
   input  logic        req_tuser,   // [0] operation

   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] temperature, [12:11] range_status

   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import rtd_pkg::*;

   // configuration registers
   logic [23:0]              low_limit_ff, low_limit_in;
   logic [23:0]              high_limit_ff, high_limit_in;
   logic signed [TEMP_W-1:0] low_temp_ff, low_temp_in;
   logic signed [TEMP_W-1:0] high_temp_ff, high_temp_in;
   logic [8:0]               offset_ff, offset_in;
   logic [9:0]               entries_ff, entries_in;

   cfg_type                  cfg;
   logic [IDX_W-1:0]         last_index;

   // queue handshake between front and back
   logic                     q_push;
   cmd_type                  q_cmd;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_valid;
   cmd_type                  q_head;

   logic signed [TEMP_W-1:0] rsp_temp;
   logic [1:0]               rsp_status;

   // register writes, indexes past the list are ignored
   always_comb begin
      low_limit_in  = low_limit_ff;
      high_limit_in = high_limit_ff;
      low_temp_in   = low_temp_ff;
      high_temp_in  = high_temp_ff;
      offset_in     = offset_ff;
      entries_in    = entries_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOW_LIMIT:  low_limit_in  = csr_wdata;
            CSR_HIGH_LIMIT: high_limit_in = csr_wdata;
            CSR_LOW_TEMP:   low_temp_in   = $signed(csr_wdata[TEMP_W-1:0]);
            CSR_HIGH_TEMP:  high_temp_in  = $signed(csr_wdata[TEMP_W-1:0]);
            CSR_OFFSET:     offset_in     = csr_wdata[8:0];
            CSR_ENTRIES:    entries_in    = csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= RST_LOW_LIMIT;
         high_limit_ff <= RST_HIGH_LIMIT;
         low_temp_ff   <= RST_LOW_TEMP;
         high_temp_ff  <= RST_HIGH_TEMP;
         offset_ff     <= RST_OFFSET;
         entries_ff    <= RST_ENTRIES;
      end else begin
         low_limit_ff  <= low_limit_in;
         high_limit_ff <= high_limit_in;
         low_temp_ff   <= low_temp_in;
         high_temp_ff  <= high_temp_in;
         offset_ff     <= offset_in;
         entries_ff    <= entries_in;
      end
   end

   // entry count saturated to 1..TABLE_DEPTH, kept as the last searched index
   always_comb begin
      if (entries_ff == '0) begin
         last_index = '0;
      end else if (32'(entries_ff) > 32'(TABLE_DEPTH)) begin
         last_index = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_index = IDX_W'(32'(entries_ff) - 32'd1);
      end
   end

   always_comb begin
      cfg.low_limit  = low_limit_ff;
      cfg.high_limit = high_limit_ff;
      cfg.low_temp   = low_temp_ff;
      cfg.high_temp  = high_temp_ff;
      cfg.offset     = offset_ff;
      cfg.last_index = last_index;
   end

   // front: accept and classify
   rtd_front u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cfg       (cfg),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   // command queue keeps loads and conversions in arrival order
   rtd_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_cmd  (q_head)
   );

   // back: table writes, search and result register
   rtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head_valid(q_valid),
      .head_cmd  (q_head),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_temp  (rsp_temp),
      .rsp_status(rsp_status)
   );

   assign rsp_tdata = {3'b000, rsp_status, rsp_temp};

   // the front never pushes into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   // the back never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   // a result always carries a defined range status
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == RANGE_OK || rsp_status == RANGE_LOW ||
                      rsp_status == RANGE_HIGH))
      else $error("undefined range status on result");

   // a waiting result stays offered with unchanged data until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while waiting");

endmodule
